// ===== design/wsjq_pkg.sv =====
// Shared types and codes for the work-stealing job queue block.
// No dependencies; imported by work_stealing_job_queues and wsjq_qctl.
`default_nettype none

package wsjq_pkg;

    localparam int DEF_NUM_WORKERS = 4;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int OP_W    = 2;
    localparam int JOB_W   = 64;
    localparam int WID_W   = 2;
    localparam int ST_W    = 3;
    localparam int SRC_W   = 2;
    localparam int TOTAL_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ  = 2'd0,
        OP_NEXT = 2'd1,
        OP_STOP = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_QUEUED       = 3'd0,
        ST_DROP_STOPPED = 3'd1,
        ST_DROP_FULL    = 3'd2,
        ST_GIVEN        = 3'd3,
        ST_NONE         = 3'd4,
        ST_STOP_DONE    = 3'd5
    } t_status;

    // pointer update request for the selected queue
    typedef struct packed {
        logic push;
        logic pop;
    } t_qcmd;

    // state of the selected queue
    typedef struct packed {
        logic empty;
        logic full;
    } t_qflags;

endpackage

`default_nettype wire

// ===== design/work_stealing_job_queues.sv =====
// Work-stealing job queues: one bounded FIFO of 64-bit job ids per worker, round-robin
// submission, own-queue-first pop with a one-queue-per-cycle steal scan, and a stop command
// that closes the queues to pushes while pops still drain. One item is handled at a time and
// the input stays stalled until its result is registered. An enqueue, stop, unused code or a
// next request with no jobs held passes through the execute state, then the done state. A
// next request with jobs held runs the steal scan between them, which checks one queue per
// cycle starting at the requesting worker. A result still stalled downstream holds the block
// in its last step. The result waits in an output register, and a new item is taken while it
// waits.
// Depends on wsjq_pkg, wsjq_qctl and wsjq_ram.
`default_nettype none

module work_stealing_job_queues #(
    parameter int NUM_WORKERS = wsjq_pkg::DEF_NUM_WORKERS,
    parameter int QUEUE_DEPTH = wsjq_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [wsjq_pkg::OP_W-1:0]     i_operation,
    input  wire logic [wsjq_pkg::JOB_W-1:0]    i_job_id,
    input  wire logic [wsjq_pkg::WID_W-1:0]    i_worker_id,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [wsjq_pkg::ST_W-1:0]     o_status,
    output logic      [wsjq_pkg::JOB_W-1:0]    o_job_id_out,
    output logic      [wsjq_pkg::SRC_W-1:0]    o_source_queue,
    output logic      [wsjq_pkg::TOTAL_W-1:0]  o_total_jobs
);

    import wsjq_pkg::*;

    localparam int WW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int SLOTS = NUM_WORKERS * QUEUE_DEPTH;
    localparam int AW = $clog2(SLOTS);
    localparam int TW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [JOB_W-1:0] r_job, n_job;
    logic [WW-1:0]    r_scan_q, n_scan_q;
    logic [WW-1:0]    r_submit, n_submit;
    logic [TW-1:0]    r_total, n_total;
    logic             r_stopped, n_stopped;
    t_status          r_status, n_status;
    logic [WW-1:0]    r_src, n_src;

    logic             r_o_valid, n_o_valid;
    t_status          r_o_status, n_o_status;
    logic [JOB_W-1:0] r_o_job, n_o_job;
    logic [SRC_W-1:0] r_o_src, n_o_src;
    logic [TOTAL_W-1:0] r_o_total, n_o_total;

    logic [4:0]       wid_mod;
    logic             accept;
    logic             out_free;

    logic [WW-1:0]    q_sel;
    t_qcmd            q_cmd;
    t_qflags          q_flags;
    logic [PW-1:0]    q_head;
    logic [PW-1:0]    q_tail;

    logic             ram_we;
    logic             ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [JOB_W-1:0] ram_rdata;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign q_sel    = (r_state == S_SCAN) ? r_scan_q : r_submit;

    // worker id taken modulo the worker count
    always_comb begin
        wid_mod = {3'b000, i_worker_id};
        for (int k = 0; k < 3; k++) begin
            if (wid_mod >= 5'(NUM_WORKERS)) begin
                wid_mod = wid_mod - 5'(NUM_WORKERS);
            end
        end
    end

    assign ram_waddr = AW'(r_submit) * AW'(QUEUE_DEPTH) + AW'(q_tail);
    assign ram_raddr = AW'(r_scan_q) * AW'(QUEUE_DEPTH) + AW'(q_head);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_job      = r_job;
        n_scan_q   = r_scan_q;
        n_submit   = r_submit;
        n_total    = r_total;
        n_stopped  = r_stopped;
        n_status   = r_status;
        n_src      = r_src;
        n_o_valid  = r_o_valid && i_stall;
        n_o_status = r_o_status;
        n_o_job    = r_o_job;
        n_o_src    = r_o_src;
        n_o_total  = r_o_total;
        q_cmd      = '0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op     = t_op'(i_operation);
                    n_job    = i_job_id;
                    n_scan_q = WW'(wid_mod);
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_src   = '0;
                n_state = S_DONE;
                case (r_op)
                    OP_ENQ: begin
                        if (r_stopped) begin
                            n_status = ST_DROP_STOPPED;
                        end else begin
                            n_src    = r_submit;
                            n_submit = (r_submit == WW'(NUM_WORKERS - 1)) ?
                                       '0 : r_submit + 1'b1;
                            if (q_flags.full) begin
                                n_status = ST_DROP_FULL;
                            end else begin
                                ram_we        = 1'b1;
                                q_cmd.push    = 1'b1;
                                n_total       = r_total + 1'b1;
                                n_status      = ST_QUEUED;
                            end
                        end
                    end
                    OP_NEXT: begin
                        n_status = ST_NONE;
                        if (r_total != '0) begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_STOP: begin
                        n_stopped = 1'b1;
                        n_status  = ST_STOP_DONE;
                    end
                    default: begin
                        n_status = ST_NONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (!q_flags.empty) begin
                    ram_re    = 1'b1;
                    q_cmd.pop = 1'b1;
                    n_total   = r_total - 1'b1;
                    n_status  = ST_GIVEN;
                    n_src     = r_scan_q;
                    n_state   = S_DONE;
                end else begin
                    n_scan_q = (r_scan_q == WW'(NUM_WORKERS - 1)) ?
                               '0 : r_scan_q + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_job    = (r_status == ST_GIVEN) ? ram_rdata : '0;
                    n_o_src    = SRC_W'(r_src);
                    n_o_total  = TOTAL_W'(r_total);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_submit  <= '0;
            r_total   <= '0;
            r_stopped <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_submit  <= n_submit;
            r_total   <= n_total;
            r_stopped <= n_stopped;
            r_o_valid <= n_o_valid;
        end
        r_op       <= n_op;
        r_job      <= n_job;
        r_scan_q   <= n_scan_q;
        r_status   <= n_status;
        r_src      <= n_src;
        r_o_status <= n_o_status;
        r_o_job    <= n_o_job;
        r_o_src    <= n_o_src;
        r_o_total  <= n_o_total;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_job_id_out   = r_o_job;
    assign o_source_queue = r_o_src;
    assign o_total_jobs   = r_o_total;

    wsjq_qctl #(
        .NUM_WORKERS (NUM_WORKERS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_qctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sel   (q_sel),
        .i_cmd   (q_cmd),
        .o_flags (q_flags),
        .o_head  (q_head),
        .o_tail  (q_tail)
    );

    wsjq_ram #(
        .WIDTH (JOB_W),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_job),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    a_scan_has_jobs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_total != '0))
        else $error("steal scan with no jobs held");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_o_valid && i_stall) |=> (r_state == S_DONE))
        else $error("result overwrote a pending transfer");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(SLOTS))
        else $error("job count beyond capacity");

endmodule

`default_nettype wire

// ===== design/wsjq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wsjq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/wsjq_qctl.sv =====
// Head, tail and fill bookkeeping for all worker queues.
// Depends on wsjq_pkg (command and flag structs).
`default_nettype none

module wsjq_qctl #(
    parameter  int NUM_WORKERS = wsjq_pkg::DEF_NUM_WORKERS,
    parameter  int QUEUE_DEPTH = wsjq_pkg::DEF_QUEUE_DEPTH,
    localparam int WW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1,
    localparam int PW = $clog2(QUEUE_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [WW-1:0]     i_sel,
    input  wire wsjq_pkg::t_qcmd   i_cmd,
    output wsjq_pkg::t_qflags      o_flags,
    output logic      [PW-1:0]     o_head,
    output logic      [PW-1:0]     o_tail
);

    import wsjq_pkg::*;

    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic [PW-1:0] r_head [NUM_WORKERS];
    logic [PW-1:0] r_tail [NUM_WORKERS];
    logic [FW-1:0] r_fill [NUM_WORKERS];

    function automatic logic [PW-1:0] f_wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NUM_WORKERS; w++) begin
                r_head[w] <= '0;
                r_tail[w] <= '0;
                r_fill[w] <= '0;
            end
        end else if (i_cmd.push) begin
            r_tail[i_sel] <= f_wrap_inc(r_tail[i_sel]);
            r_fill[i_sel] <= r_fill[i_sel] + 1'b1;
        end else if (i_cmd.pop) begin
            r_head[i_sel] <= f_wrap_inc(r_head[i_sel]);
            r_fill[i_sel] <= r_fill[i_sel] - 1'b1;
        end
    end

    assign o_head        = r_head[i_sel];
    assign o_tail        = r_tail[i_sel];
    assign o_flags.empty = (r_fill[i_sel] == '0);
    assign o_flags.full  = (r_fill[i_sel] == FW'(QUEUE_DEPTH));

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !o_flags.full)
        else $error("push to a full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> !o_flags.empty)
        else $error("pop from an empty queue");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push && i_cmd.pop))
        else $error("push and pop in the same cycle");

endmodule

`default_nettype wire
